// ----- rtl/lpm_pkg.sv -----
package lpm_pkg;

  localparam int ADDR_W = 32;
  localparam int LEN_W  = 6;
  localparam int PORT_W = 4;
  localparam int TTL_W  = 8;
  localparam int STAT_W = 3;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(32);

  localparam logic [STAT_W-1:0] ST_FORWARDED = 3'd0;
  localparam logic [STAT_W-1:0] ST_EXPIRED   = 3'd1;
  localparam logic [STAT_W-1:0] ST_NO_ROUTE  = 3'd2;
  localparam logic [STAT_W-1:0] ST_ADDED     = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  len;
    logic              has_hop;
    logic [ADDR_W-1:0] hop;
    logic [PORT_W-1:0] port;
  } entry_t;

  // lookup travelling down the row, carrying the best route so far
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              found;
    logic [LEN_W-1:0]  best_len;
    logic              has_hop;
    logic [ADDR_W-1:0] hop;
    logic [PORT_W-1:0] port;
  } token_t;

  function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] m;
    if (len == '0) begin
      m = '0;
    end else begin
      m = {ADDR_W{1'b1}} << (MAX_LEN - len);
    end
    return m;
  endfunction

endpackage

// ----- rtl/lpm_if.sv -----
interface lpm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [lpm_pkg::ADDR_W-1:0]  address;
  logic [lpm_pkg::LEN_W-1:0]   prefix_len;
  logic                        hop_valid;
  logic [lpm_pkg::ADDR_W-1:0]  hop_addr;
  logic [lpm_pkg::PORT_W-1:0]  port_in;
  logic [lpm_pkg::TTL_W-1:0]   ttl_in;

  modport source (output valid, kind, address, prefix_len, hop_valid, hop_addr, port_in,
                  ttl_in, input ready);
  modport sink (input valid, kind, address, prefix_len, hop_valid, hop_addr, port_in,
                ttl_in, output ready);
endinterface

interface lpm_out_if;
  logic                        valid;
  logic                        ready;
  logic [lpm_pkg::STAT_W-1:0]  status;
  logic [lpm_pkg::PORT_W-1:0]  port_out;
  logic [lpm_pkg::ADDR_W-1:0]  hop_out;
  logic [lpm_pkg::TTL_W-1:0]   ttl_out;

  modport source (output valid, status, port_out, hop_out, ttl_out, input ready);
  modport sink (input valid, status, port_out, hop_out, ttl_out, output ready);
endinterface

// ----- rtl/lpm_cell.sv -----
module lpm_cell #(
  parameter int CNT_W = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  lpm_pkg::entry_t     wr_entry,
  input  logic                tok_vld_i,
  input  lpm_pkg::token_t     tok_i,
  input  logic [CNT_W-1:0]    rem_i,
  output logic                tok_vld_o,
  output lpm_pkg::token_t     tok_o,
  output logic [CNT_W-1:0]    rem_o
);

  lpm_pkg::entry_t            entry_r;
  logic                       tok_vld_r;
  lpm_pkg::token_t            tok_r, tok_nxt;
  logic [CNT_W-1:0]           rem_r, rem_nxt;
  logic [lpm_pkg::ADDR_W-1:0] mask;
  logic                       live;
  logic                       hit;

  always_comb begin
    mask = lpm_pkg::len_mask(entry_r.len);
    // rem counts the routes still to visit, so unwritten cells are never looked at
    live = (rem_i != '0);
    hit  = live && (((entry_r.prefix ^ tok_i.addr) & mask) == '0) &&
           (!tok_i.found || (entry_r.len > tok_i.best_len));
    tok_nxt = tok_i;
    if (hit) begin
      tok_nxt.found    = 1'b1;
      tok_nxt.best_len = entry_r.len;
      tok_nxt.has_hop  = entry_r.has_hop;
      tok_nxt.hop      = entry_r.hop;
      tok_nxt.port     = entry_r.port;
    end
    rem_nxt = live ? rem_i - CNT_W'(1) : rem_i;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r <= 1'b0;
    end else begin
      tok_vld_r <= tok_vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_vld_i) begin
      tok_r <= tok_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign tok_vld_o = tok_vld_r;
  assign tok_o     = tok_r;
  assign rem_o     = rem_r;

endmodule

// ----- rtl/longest_prefix_match_router_core.sv -----
// add and expired-ttl items: result valid in the cycle after the item is taken, one item a
// cycle while the output is not stalled; lookup items: the result is registered once the
// lookup has walked the row of TABLE_DEPTH route cells, one cell a cycle
// no new item is taken while a lookup walks the row
// reset (rst_n low, synchronous) empties the table count and clears all handshake state;
// route contents stay undefined until written, there is no clearing pass
module longest_prefix_match_router_core #(
  parameter int TABLE_DEPTH = 64,
  parameter int PORT_COUNT  = 16
) (
  input logic       clk,
  input logic       rst_n,
  lpm_in_if.sink    in_ch,
  lpm_out_if.source out_ch
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int PORT_VALS = 1 << lpm_pkg::PORT_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                       state_r, state_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [lpm_pkg::TTL_W-1:0]  ttl_r;

  logic                       out_vld_r, out_vld_nxt;
  logic [lpm_pkg::STAT_W-1:0] out_status_r;
  logic [lpm_pkg::PORT_W-1:0] out_port_r;
  logic [lpm_pkg::ADDR_W-1:0] out_hop_r;
  logic [lpm_pkg::TTL_W-1:0]  out_ttl_r;

  logic                       res_vld;
  logic [lpm_pkg::STAT_W-1:0] res_status;
  logic [lpm_pkg::PORT_W-1:0] res_port;
  logic [lpm_pkg::ADDR_W-1:0] res_hop;
  logic [lpm_pkg::TTL_W-1:0]  res_ttl;

  logic                       acc;
  logic                       expired;
  logic                       full;
  logic                       wr_go;
  lpm_pkg::entry_t            wr_entry;
  logic [lpm_pkg::PORT_W-1:0] port_mod [PORT_VALS];

  logic                       tok_vld [TABLE_DEPTH+1];
  lpm_pkg::token_t            tok     [TABLE_DEPTH+1];
  logic [CNT_W-1:0]           rem     [TABLE_DEPTH+1];

  // port reduction table, worked out at elaboration
  for (genvar v = 0; v < PORT_VALS; v++) begin : g_pmod
    assign port_mod[v] = lpm_pkg::PORT_W'(v % PORT_COUNT);
  end

  assign in_ch.ready = (state_r == ST_IDLE) && (!out_vld_r || out_ch.ready);
  assign acc         = in_ch.valid && in_ch.ready;
  assign expired     = (in_ch.ttl_in <= lpm_pkg::TTL_W'(1));
  assign full        = (count_r == CNT_W'(TABLE_DEPTH));
  assign wr_go       = acc && in_ch.kind && !full;

  always_comb begin
    wr_entry.prefix  = in_ch.address;
    wr_entry.len     = (in_ch.prefix_len > lpm_pkg::MAX_LEN) ? lpm_pkg::MAX_LEN
                                                             : in_ch.prefix_len;
    wr_entry.has_hop = in_ch.hop_valid;
    wr_entry.hop     = in_ch.hop_addr;
    wr_entry.port    = port_mod[in_ch.port_in];
  end

  // head of the row: a fresh lookup with nothing found yet
  always_comb begin
    tok_vld[0]      = acc && !in_ch.kind && !expired;
    tok[0].addr     = in_ch.address;
    tok[0].found    = 1'b0;
    tok[0].best_len = '0;
    tok[0].has_hop  = 1'b0;
    tok[0].hop      = '0;
    tok[0].port     = '0;
    rem[0]          = count_r;
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    lpm_cell #(
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .wr_en     (wr_go && (count_r == CNT_W'(g))),
      .wr_entry  (wr_entry),
      .tok_vld_i (tok_vld[g]),
      .tok_i     (tok[g]),
      .rem_i     (rem[g]),
      .tok_vld_o (tok_vld[g+1]),
      .tok_o     (tok[g+1]),
      .rem_o     (rem[g+1])
    );
  end

  always_comb begin
    res_vld    = 1'b0;
    res_status = lpm_pkg::ST_NO_ROUTE;
    res_port   = '0;
    res_hop    = '0;
    res_ttl    = '0;
    if (acc && in_ch.kind) begin
      res_vld    = 1'b1;
      res_status = full ? lpm_pkg::ST_FULL : lpm_pkg::ST_ADDED;
    end else if (acc && expired) begin
      res_vld    = 1'b1;
      res_status = lpm_pkg::ST_EXPIRED;
    end else if (tok_vld[TABLE_DEPTH]) begin
      res_vld = 1'b1;
      if (tok[TABLE_DEPTH].found) begin
        res_status = lpm_pkg::ST_FORWARDED;
        res_port   = tok[TABLE_DEPTH].port;
        res_hop    = tok[TABLE_DEPTH].has_hop ? tok[TABLE_DEPTH].hop : tok[TABLE_DEPTH].addr;
        res_ttl    = ttl_r - lpm_pkg::TTL_W'(1);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (tok_vld[0]) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tok_vld[TABLE_DEPTH]) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    count_nxt   = wr_go ? count_r + CNT_W'(1) : count_r;
    out_vld_nxt = res_vld || (out_vld_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      ttl_r <= in_ch.ttl_in;
    end
    if (res_vld) begin
      out_status_r <= res_status;
      out_port_r   <= res_port;
      out_hop_r    <= res_hop;
      out_ttl_r    <= res_ttl;
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.port_out = out_port_r;
  assign out_ch.hop_out  = out_hop_r;
  assign out_ch.ttl_out  = out_ttl_r;

endmodule

// ----- rtl/lpm_checker.sv -----
module lpm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_kind,
  input logic [lpm_pkg::TTL_W-1:0]  in_ttl,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [lpm_pkg::STAT_W-1:0] out_status,
  input logic [lpm_pkg::PORT_W-1:0] out_port,
  input logic [lpm_pkg::ADDR_W-1:0] out_hop,
  input logic [lpm_pkg::TTL_W-1:0]  out_ttl
);

  // a stalled result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_hop))
    else $error("result changed while stalled");

  // an add item answers on the next cycle
  a_add_resp: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind |=>
      out_valid && (out_status == lpm_pkg::ST_ADDED || out_status == lpm_pkg::ST_FULL))
    else $error("add item not answered in time");

  // expired datagram is answered at once with no lookup
  a_expired: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_kind && (in_ttl <= lpm_pkg::TTL_W'(1)) |=>
      out_valid && (out_status == lpm_pkg::ST_EXPIRED))
    else $error("expired datagram not answered in time");

  // a lookup holds off the input and has no result on the following cycle
  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_kind && (in_ttl > lpm_pkg::TTL_W'(1)) |=>
      !in_ready && !out_valid)
    else $error("input taken during a lookup");

  // anything other than a forward carries zero fields
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != lpm_pkg::ST_FORWARDED) |->
      (out_port == '0) && (out_hop == '0) && (out_ttl == '0))
    else $error("non-forward result with non-zero fields");

endmodule

bind longest_prefix_match_router_core lpm_checker u_lpm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_kind    (in_ch.kind),
  .in_ttl     (in_ch.ttl_in),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_port   (out_ch.port_out),
  .out_hop    (out_ch.hop_out),
  .out_ttl    (out_ch.ttl_out)
);

// ----- sim/longest_prefix_match_router_core_tb.sv -----
module longest_prefix_match_router_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 64;
  localparam int PORT_COUNT  = 16;
  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_ADD    = 1'b1;
  localparam int ITEMS_PER_PHASE = 220;

  typedef struct packed {
    logic                       kind;
    logic [lpm_pkg::ADDR_W-1:0] address;
    logic [lpm_pkg::LEN_W-1:0]  prefix_len;
    logic                       hop_valid;
    logic [lpm_pkg::ADDR_W-1:0] hop_addr;
    logic [lpm_pkg::PORT_W-1:0] port_in;
    logic [lpm_pkg::TTL_W-1:0]  ttl_in;
  } lpm_req_t;

  typedef struct packed {
    logic [lpm_pkg::STAT_W-1:0] status;
    logic [lpm_pkg::PORT_W-1:0] port;
    logic [lpm_pkg::ADDR_W-1:0] hop_out;
    logic [lpm_pkg::TTL_W-1:0]  ttl;
  } lpm_verdict_t;

  class route_scoreboard;
    logic [lpm_pkg::ADDR_W-1:0] tbl_prefix[TABLE_DEPTH];
    logic [lpm_pkg::LEN_W-1:0]  tbl_len[TABLE_DEPTH];
    logic                       tbl_has_hop[TABLE_DEPTH];
    logic [lpm_pkg::ADDR_W-1:0] tbl_hop[TABLE_DEPTH];
    logic [lpm_pkg::PORT_W-1:0] tbl_port[TABLE_DEPTH];
    int unsigned                routes_held;
    lpm_verdict_t               awaited_verdicts[$];
    int unsigned                mismatches;
    int unsigned                items_taken;
    int unsigned                status_seen[5];

    function new();
      routes_held = 0;
      mismatches  = 0;
      items_taken = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int unsigned pending();
      return awaited_verdicts.size();
    endfunction

    // updates the route table copy and works out what the block should answer
    function lpm_verdict_t forward_decision(input lpm_req_t r);
      lpm_verdict_t               v;
      logic [lpm_pkg::ADDR_W-1:0] mask;
      int                         best;
      v = '0;
      if (r.kind == KIND_ADD) begin
        if (routes_held >= TABLE_DEPTH) begin
          v.status = lpm_pkg::ST_FULL;
        end else begin
          tbl_prefix[routes_held]  = r.address;
          tbl_len[routes_held]     = (r.prefix_len > lpm_pkg::MAX_LEN) ? lpm_pkg::MAX_LEN
                                                                       : r.prefix_len;
          tbl_has_hop[routes_held] = r.hop_valid;
          tbl_hop[routes_held]     = r.hop_addr;
          tbl_port[routes_held]    = lpm_pkg::PORT_W'(r.port_in % PORT_COUNT);
          routes_held++;
          v.status = lpm_pkg::ST_ADDED;
        end
      end else if (r.ttl_in <= 1) begin
        v.status = lpm_pkg::ST_EXPIRED;
      end else begin
        best = -1;
        for (int i = 0; i < routes_held; i++) begin
          // shift by the full width leaves zero, so a length of 32 gives all ones
          mask = ~({lpm_pkg::ADDR_W{1'b1}} >> tbl_len[i]);
          if (((tbl_prefix[i] ^ r.address) & mask) == '0 &&
              (best < 0 || tbl_len[i] > tbl_len[best])) begin
            best = i;
          end
        end
        if (best < 0) begin
          v.status = lpm_pkg::ST_NO_ROUTE;
        end else begin
          v.status  = lpm_pkg::ST_FORWARDED;
          v.port    = tbl_port[best];
          v.hop_out = tbl_has_hop[best] ? tbl_hop[best] : r.address;
          v.ttl     = r.ttl_in - 1'b1;
        end
      end
      return v;
    endfunction

    function void note_item(input lpm_req_t r);
      items_taken++;
      awaited_verdicts.push_back(forward_decision(r));
    endfunction

    function void check_result(input lpm_verdict_t got);
      lpm_verdict_t want;
      bit           bad;
      if (awaited_verdicts.size() == 0) begin
        $error("unexpected result: status %0d port %0d hop_out %h ttl %0d",
               got.status, got.port, got.hop_out, got.ttl);
        mismatches++;
        return;
      end
      want = awaited_verdicts.pop_front();
      bad  = 1'b0;
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        bad = 1'b1;
      end
      if (got.port !== want.port) begin
        $error("port_out: expected %0d, got %0d", want.port, got.port);
        bad = 1'b1;
      end
      if (got.hop_out !== want.hop_out) begin
        $error("hop_out: expected %h, got %h", want.hop_out, got.hop_out);
        bad = 1'b1;
      end
      if (got.ttl !== want.ttl) begin
        $error("ttl_out: expected %0d, got %0d", want.ttl, got.ttl);
        bad = 1'b1;
      end
      if (bad) mismatches++;
      if (want.status <= lpm_pkg::ST_FULL) status_seen[want.status]++;
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  route_scoreboard            sb;
  logic [lpm_pkg::ADDR_W-1:0] route_bases[$];

  lpm_in_if  in_ch();
  lpm_out_if out_ch();

  longest_prefix_match_router_core #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .PORT_COUNT (PORT_COUNT)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result('{out_ch.status, out_ch.port_out, out_ch.hop_out, out_ch.ttl_out});
    end
  end

  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // entered and left at a falling edge; valid stays high into the next item
  task automatic push_item(input logic kind, input logic [lpm_pkg::ADDR_W-1:0] addr,
                           input logic [lpm_pkg::LEN_W-1:0] len, input logic hv,
                           input logic [lpm_pkg::ADDR_W-1:0] hop,
                           input logic [lpm_pkg::PORT_W-1:0] port,
                           input logic [lpm_pkg::TTL_W-1:0] ttl);
    lpm_req_t r;
    r = '{kind, addr, len, hv, hop, port, ttl};
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= r.kind;
    in_ch.address    <= r.address;
    in_ch.prefix_len <= r.prefix_len;
    in_ch.hop_valid  <= r.hop_valid;
    in_ch.hop_addr   <= r.hop_addr;
    in_ch.port_in    <= r.port_in;
    in_ch.ttl_in     <= r.ttl_in;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(r);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [lpm_pkg::ADDR_W-1:0] a;
    logic [lpm_pkg::TTL_W-1:0]  ttl;
    int                         pick;
    int                         len;
    sb = new();
    in_ch.valid      = 1'b0;
    in_ch.kind       = KIND_LOOKUP;
    in_ch.address    = '0;
    in_ch.prefix_len = '0;
    in_ch.hop_valid  = 1'b0;
    in_ch.hop_addr   = '0;
    in_ch.port_in    = '0;
    in_ch.ttl_in     = '0;
    out_ch.ready     = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table, then expiry at both low ttl values
    push_item(KIND_LOOKUP, 32'h0A00_0001, 6'd0, 1'b0, 32'h0, 4'd0, 8'd64);
    push_item(KIND_LOOKUP, 32'h0A00_0001, 6'd8, 1'b1, 32'hFFFF_FFFF, 4'd15, 8'd0);
    push_item(KIND_LOOKUP, 32'hFFFF_FFFF, 6'd63, 1'b1, 32'hFFFF_FFFF, 4'd15, 8'd1);
    push_item(KIND_ADD, 32'h0A00_0000, 6'd8, 1'b1, 32'hC0A8_0101, 4'd3, 8'd0);
    push_item(KIND_ADD, 32'h0A01_0000, 6'd16, 1'b0, 32'hDEAD_BEEF, 4'd5, 8'd255);
    push_item(KIND_ADD, 32'h0A01_0203, 6'd32, 1'b1, 32'hAC10_0001, 4'd15, 8'd7);
    // same prefix and length again: the earlier route must keep winning
    push_item(KIND_ADD, 32'h0A01_FFFF, 6'd16, 1'b1, 32'h0102_0304, 4'd7, 8'd0);
    // over-long lengths saturate to a host route
    push_item(KIND_ADD, 32'hFFFF_FFFF, 6'd63, 1'b1, 32'hFFFF_FFFF, 4'd0, 8'd0);
    push_item(KIND_ADD, 32'h0000_0000, 6'd33, 1'b0, 32'h0, 4'd9, 8'd0);
    push_item(KIND_ADD, 32'h8000_0000, 6'd1, 1'b1, 32'h0, 4'd12, 8'd0);
    push_item(KIND_LOOKUP, 32'h0A01_0203, 6'd0, 1'b0, 32'h0, 4'd0, 8'd255);
    push_item(KIND_LOOKUP, 32'h0A01_0204, 6'd0, 1'b0, 32'h0, 4'd0, 8'd2);
    push_item(KIND_LOOKUP, 32'h0AC8_0001, 6'd0, 1'b0, 32'h0, 4'd0, 8'd100);
    push_item(KIND_LOOKUP, 32'hFFFF_FFFF, 6'd0, 1'b0, 32'h0, 4'd0, 8'd10);
    push_item(KIND_LOOKUP, 32'hFFFF_FFFE, 6'd0, 1'b0, 32'h0, 4'd0, 8'd3);
    push_item(KIND_LOOKUP, 32'h0000_0000, 6'd0, 1'b0, 32'h0, 4'd0, 8'd128);
    push_item(KIND_LOOKUP, 32'h0000_0001, 6'd0, 1'b0, 32'h0, 4'd0, 8'd128);
    // default route, then addresses only it can carry, and an expired datagram
    push_item(KIND_ADD, 32'h1234_5678, 6'd0, 1'b1, 32'hFFFF_FFFF, 4'd1, 8'd0);
    push_item(KIND_LOOKUP, 32'h0000_0001, 6'd63, 1'b1, 32'hFFFF_FFFF, 4'd15, 8'd255);
    push_item(KIND_LOOKUP, 32'h7FFF_FFFF, 6'd32, 1'b0, 32'h0, 4'd8, 8'd2);
    push_item(KIND_LOOKUP, 32'h0A01_0203, 6'd0, 1'b0, 32'h0, 4'd0, 8'd1);
    route_bases.push_back(32'h0A00_0000);
    route_bases.push_back(32'h0A01_0203);
    route_bases.push_back(32'hFFFF_FFFF);
    route_bases.push_back(32'h0000_0000);
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 78;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 78;
        end
        default: begin
          send_idle_pct = 20;
          stall_pct     = 20;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(99) < 12) begin
          // half of the new routes nest inside or beside existing ones
          if ($urandom_range(1)) begin
            a = route_bases[$urandom_range(route_bases.size() - 1)] ^
                (lpm_pkg::ADDR_W'($urandom) >> $urandom_range(8, 32));
          end else begin
            a = $urandom;
          end
          pick = $urandom_range(99);
          if (pick < 3) len = 0;
          else if (pick < 13) len = $urandom_range(33, 63);
          else len = $urandom_range(1, 32);
          route_bases.push_back(a);
          push_item(KIND_ADD, a, lpm_pkg::LEN_W'(len), 1'($urandom_range(1)), $urandom,
                    lpm_pkg::PORT_W'($urandom_range(15)),
                    lpm_pkg::TTL_W'($urandom_range(255)));
        end else begin
          if ($urandom_range(99) < 75) begin
            a = route_bases[$urandom_range(route_bases.size() - 1)] ^
                (lpm_pkg::ADDR_W'($urandom) >> $urandom_range(0, 32));
          end else begin
            a = $urandom;
          end
          ttl = ($urandom_range(99) < 10) ? lpm_pkg::TTL_W'($urandom_range(1))
                                          : lpm_pkg::TTL_W'($urandom_range(2, 255));
          push_item(KIND_LOOKUP, a, lpm_pkg::LEN_W'($urandom_range(63)),
                    1'($urandom_range(1)), $urandom,
                    lpm_pkg::PORT_W'($urandom_range(15)), ttl);
        end
      end
      drain_results();
    end

    repeat (TABLE_DEPTH + 10) @(posedge clk);
    $display("%0d items over four handshake phases, %0d routes held at the end",
             sb.items_taken, sb.routes_held);
    $display("forwarded %0d, expired %0d, no route %0d, added %0d, table full %0d",
             sb.status_seen[lpm_pkg::ST_FORWARDED], sb.status_seen[lpm_pkg::ST_EXPIRED],
             sb.status_seen[lpm_pkg::ST_NO_ROUTE], sb.status_seen[lpm_pkg::ST_ADDED],
             sb.status_seen[lpm_pkg::ST_FULL]);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
